/* hdl/hmtm_pkg.sv */
// ---------------------------------------------------------------------------
// hmtm_pkg
// Shared types and constants of the heightmap tile mesher.
// ---------------------------------------------------------------------------
package hmtm_pkg;

  localparam int COORD_W = 12;
  localparam int POS_W   = 13;
  localparam int H_W     = 8;
  localparam int STEP_W  = 8;
  localparam int Q14_W   = 16;
  localparam int TEX_W   = 5;

  localparam logic [STEP_W-1:0] STEP_RESET = 8'd10;
  localparam int QUEUE_DEPTH_DEF = 2;

  // atlas thresholds on the tile's largest height
  localparam logic [H_W-1:0] TH_SNOW  = 8'd231;
  localparam logic [H_W-1:0] TH_ROCK  = 8'd205;
  localparam logic [H_W-1:0] TH_GRASS = 8'd129;
  localparam logic [H_W-1:0] TH_SAND  = 8'd77;

  typedef logic signed [8:0]  diff_t;
  typedef logic signed [16:0] vcomp_t;
  typedef logic signed [15:0] q14_t;
  typedef vcomp_t [2:0]       vec3_t;
  typedef q14_t   [2:0]       nvec_t;

  typedef struct packed {
    logic [COORD_W-1:0]     tile_x;
    logic [COORD_W-1:0]     tile_z;
    logic [3:0][H_W-1:0]    h;
    logic [STEP_W-1:0]      step;
    diff_t                  v1x;
    diff_t                  v1z;
    diff_t                  v2x;
    diff_t                  v2z;
    logic [1:0]             ats;
    logic [3:0]             att;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE, B_N1, B_N2, B_NA, B_HAND
  } back_state_t;

  typedef enum logic [2:0] {
    N_IDLE, N_SQ, N_L2, N_DIV, N_ROOT, N_DONE
  } norm_state_t;

endpackage

/* hdl/hmtm_ifs.sv */
// ---------------------------------------------------------------------------
// hmtm channel interfaces
// Tile input, vertex output and step register write channels.
// ---------------------------------------------------------------------------
interface hmtm_tile_if import hmtm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] tile_x;
  logic [COORD_W-1:0] tile_z;
  logic [H_W-1:0]     height_a;
  logic [H_W-1:0]     height_b;
  logic [H_W-1:0]     height_c;
  logic [H_W-1:0]     height_d;
  modport source (output valid, tile_x, tile_z, height_a, height_b, height_c, height_d,
                  input ready);
  modport sink (input valid, tile_x, tile_z, height_a, height_b, height_c, height_d,
                output ready);
endinterface

interface hmtm_vert_if import hmtm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         corner;
  logic [POS_W-1:0]   pos_x;
  logic [H_W-1:0]     pos_y;
  logic [POS_W-1:0]   pos_z;
  logic signed [Q14_W-1:0] norm_x;
  logic signed [Q14_W-1:0] norm_y;
  logic signed [Q14_W-1:0] norm_z;
  logic [TEX_W-1:0]   tex_s;
  logic [TEX_W-1:0]   tex_t;
  logic               last_vertex;
  modport source (output valid, corner, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  tex_s, tex_t, last_vertex, input ready);
  modport sink (input valid, corner, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                tex_s, tex_t, last_vertex, output ready);
endinterface

interface hmtm_cfg_if import hmtm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] step_size;
  modport source (output valid, step_size, input ready);
  modport sink (input valid, step_size, output ready);
endinterface

/* hdl/heightmap_tile_mesher.sv */
// ---------------------------------------------------------------------------
// heightmap_tile_mesher
// Terrain tile to four mesh vertices with Q1.14 normals and atlas coordinates.
// ---------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  tile     in   valid/ready   tile_x, tile_z, height_a..height_d
//  vertex   out  valid/ready   corner, pos, norm, tex, last_vertex
//  cfg      in   valid/ready   step_size (ready always high)
//
// A tile passes through the back end as one pop, three normalizer passes
// (square, sum, 31 divide steps, 16 root steps, done) on one shared unit,
// and one handoff to the vertex buffer.
// Vertex emission overlaps the next tile's normalization.
// The queue holds QUEUE_DEPTH tiles, so the tile side stays ready while the back works until the queue is full.
// rst clears control state; step_size returns to 10.
// ---------------------------------------------------------------------------
module heightmap_tile_mesher import hmtm_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  hmtm_tile_if.sink   tile,
  hmtm_vert_if.source vertex,
  hmtm_cfg_if.sink    cfg
);

  logic [STEP_W-1:0] step_size;
  logic              q_full, q_empty, push, pop;
  job_t              f_job, q_job;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst)            step_size <= STEP_RESET;
    else if (cfg.valid) step_size <= cfg.step_size;
  end

  hmtm_front u_front (
    .tile   (tile),
    .step   (step_size),
    .q_full (q_full),
    .push   (push),
    .job    (f_job)
  );

  hmtm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (f_job),
    .full  (q_full),
    .pop   (pop),
    .dout  (q_job),
    .empty (q_empty)
  );

  hmtm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_data  (q_job),
    .pop     (pop),
    .vertex  (vertex)
  );

endmodule

/* hdl/hmtm_front.sv */
// ---------------------------------------------------------------------------
// hmtm_front
// Accepts tiles, forms the two triangle direction vectors and picks the atlas tile.
// ---------------------------------------------------------------------------
module hmtm_front import hmtm_pkg::*; (
  hmtm_tile_if.sink          tile,
  input  logic [STEP_W-1:0]  step,
  input  logic               q_full,
  output logic               push,
  output job_t               job
);

  logic [H_W-1:0] m01, m23, mx;

  assign tile.ready = !q_full;
  assign push       = tile.valid && !q_full;

  always_comb begin
    m01 = (tile.height_a > tile.height_b) ? tile.height_a : tile.height_b;
    m23 = (tile.height_c > tile.height_d) ? tile.height_c : tile.height_d;
    mx  = (m01 > m23) ? m01 : m23;

    job.tile_x = tile.tile_x;
    job.tile_z = tile.tile_z;
    job.h      = {tile.height_d, tile.height_c, tile.height_b, tile.height_a};
    job.step   = step;
    job.v1x    = $signed({1'b0, tile.height_b}) - $signed({1'b0, tile.height_a});
    job.v1z    = $signed({1'b0, tile.height_c}) - $signed({1'b0, tile.height_b});
    job.v2x    = $signed({1'b0, tile.height_c}) - $signed({1'b0, tile.height_d});
    job.v2z    = $signed({1'b0, tile.height_d}) - $signed({1'b0, tile.height_a});

    if (mx >= TH_SNOW) begin
      job.ats = 2'd2; job.att = 4'd11;
    end else if (mx >= TH_ROCK) begin
      job.ats = 2'd3; job.att = 4'd11;
    end else if (mx >= TH_GRASS) begin
      job.ats = 2'd0; job.att = 4'd14;
    end else if (mx >= TH_SAND) begin
      job.ats = 2'd2; job.att = 4'd15;
    end else begin
      job.ats = 2'd0; job.att = 4'd11;
    end
  end

endmodule

/* hdl/hmtm_queue.sv */
// ---------------------------------------------------------------------------
// hmtm_queue
// Short job queue between front and back.
// ---------------------------------------------------------------------------
module hmtm_queue import hmtm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t din,
  output logic full,
  input  logic pop,
  output job_t dout,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* hdl/hmtm_norm.sv */
// ---------------------------------------------------------------------------
// hmtm_norm
// Iterative Q1.14 normalizer, three lanes: restoring divide then square root.
// ---------------------------------------------------------------------------
module hmtm_norm import hmtm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  vec3_t vec,
  output logic  done,
  output nvec_t res
);

  norm_state_t state, state_next;
  logic [4:0]  cnt;
  logic [31:0] l2;
  logic [15:0] mag  [3];
  logic        neg  [3];
  logic [30:0] sq   [3];
  logic [32:0] rem  [3];
  logic [30:0] quo  [3];
  logic [31:0] srad [3];
  logic [19:0] srem [3];
  logic [15:0] root [3];

  logic [32:0] rs    [3];
  logic        dbit  [3];
  logic [19:0] rem4  [3];
  logic [19:0] trial [3];
  logic        rbit  [3];
  logic [16:0] rinc  [3];
  logic [15:0] lo    [3];
  logic [16:0] absv  [3];

  always_ff @(posedge clk) begin
    if (rst) state <= N_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    done       = 1'b0;
    unique case (state)
      N_IDLE: if (start) state_next = N_SQ;
      N_SQ:   state_next = N_L2;
      N_L2:   state_next = N_DIV;
      N_DIV:  if (cnt == 5'd30) state_next = N_ROOT;
      N_ROOT: if (cnt == 5'd15) state_next = N_DONE;
      N_DONE: begin
        done       = 1'b1;
        state_next = start ? N_SQ : N_IDLE;
      end
      default: state_next = N_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      absv[i]  = vec[i][16] ? 17'(-$signed(vec[i])) : 17'(vec[i]);
      rs[i]    = (cnt == '0) ? rem[i] : {rem[i][31:0], 1'b0};
      dbit[i]  = rs[i] >= {1'b0, l2};
      rem4[i]  = {srem[i][17:0], srad[i][31:30]};
      trial[i] = {2'b00, root[i], 2'b01};
      rbit[i]  = rem4[i] >= trial[i];
      rinc[i]  = {1'b0, root[i]} + 17'd1;
      lo[i]    = rinc[i][16:1];
      if (l2 == '0)  res[i] = '0;
      else if (neg[i]) res[i] = -$signed(lo[i]);
      else           res[i] = $signed(lo[i]);
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      N_SQ: begin
        for (int i = 0; i < 3; i++) sq[i] <= 31'(mag[i] * mag[i]);
      end
      N_L2: begin
        l2 <= 32'(sq[0]) + 32'(sq[1]) + 32'(sq[2]);
        cnt <= '0;
        for (int i = 0; i < 3; i++) rem[i] <= {2'b00, sq[i]};
      end
      N_DIV: begin
        cnt <= (cnt == 5'd30) ? '0 : cnt + 1'b1;
        for (int i = 0; i < 3; i++) begin
          rem[i]  <= dbit[i] ? rs[i] - {1'b0, l2} : rs[i];
          quo[i]  <= {quo[i][29:0], dbit[i]};
          srad[i] <= {1'b0, quo[i][29:0], dbit[i]};
          srem[i] <= '0;
          root[i] <= '0;
        end
      end
      N_ROOT: begin
        cnt <= cnt + 1'b1;
        for (int i = 0; i < 3; i++) begin
          srem[i] <= rbit[i] ? rem4[i] - trial[i] : rem4[i];
          root[i] <= {root[i][14:0], rbit[i]};
          srad[i] <= {srad[i][29:0], 2'b00};
        end
      end
      default: ;
    endcase
    if (start && (state == N_IDLE || state == N_DONE)) begin
      for (int i = 0; i < 3; i++) begin
        mag[i] <= absv[i][15:0];
        neg[i] <= vec[i][16];
      end
    end
  end

endmodule

/* hdl/hmtm_back.sv */
// ---------------------------------------------------------------------------
// hmtm_back
// Runs the three normalizations of a tile and emits its four vertices.
// ---------------------------------------------------------------------------
module hmtm_back import hmtm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_empty,
  input  job_t        q_data,
  output logic        pop,
  hmtm_vert_if.source vertex
);

  back_state_t state, state_next;
  job_t        job;
  nvec_t       n1, n2, na;
  logic        n_start, n_done;
  vec3_t       n_vec;
  nvec_t       n_res;

  // emit buffer
  logic        e_busy;
  logic [1:0]  e_k;
  job_t        e_job;
  nvec_t       e_n1, e_n2, e_na;
  logic        hand, load;
  logic        dx, dz;
  nvec_t       nsel;

  hmtm_norm u_norm (
    .clk   (clk),
    .rst   (rst),
    .start (n_start),
    .vec   (n_vec),
    .done  (n_done),
    .res   (n_res)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    n_start    = 1'b0;
    hand       = 1'b0;
    n_vec      = '0;
    unique case (state)
      B_IDLE: begin
        n_vec = {17'(q_data.v1z), -$signed({9'b0, q_data.step}), 17'(q_data.v1x)};
        if (!q_empty) begin
          pop        = 1'b1;
          n_start    = 1'b1;
          state_next = B_N1;
        end
      end
      B_N1: begin
        n_vec = {17'(job.v2z), -$signed({9'b0, job.step}), 17'(job.v2x)};
        if (n_done) begin
          n_start    = 1'b1;
          state_next = B_N2;
        end
      end
      B_N2: begin
        for (int i = 0; i < 3; i++) n_vec[i] = 17'(n1[i]) + 17'(n_res[i]);
        if (n_done) begin
          n_start    = 1'b1;
          state_next = B_NA;
        end
      end
      B_NA: if (n_done) state_next = B_HAND;
      B_HAND: begin
        if (!e_busy) begin
          hand       = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) job <= q_data;
    if (state == B_N1 && n_done) n1 <= n_res;
    if (state == B_N2 && n_done) n2 <= n_res;
    if (state == B_NA && n_done) na <= n_res;
    if (hand) begin
      e_job <= job;
      e_n1  <= n1;
      e_n2  <= n2;
      e_na  <= na;
    end
  end

  assign load = e_busy && (!vertex.valid || vertex.ready);
  assign dx   = (e_k == 2'd1) || (e_k == 2'd2);
  assign dz   = e_k[1];

  always_comb begin
    case (e_k)
      2'd1:    nsel = e_n1;
      2'd3:    nsel = e_n2;
      default: nsel = e_na;
    endcase
    if (e_job.step == '0) nsel = '0;  // zero step: cross products vanish
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_busy       <= 1'b0;
      e_k          <= '0;
      vertex.valid <= 1'b0;
    end else begin
      if (hand) begin
        e_busy <= 1'b1;
        e_k    <= '0;
      end else if (load) begin
        e_k <= e_k + 1'b1;
        if (e_k == 2'd3) e_busy <= 1'b0;
      end
      if (load)              vertex.valid <= 1'b1;
      else if (vertex.ready) vertex.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vertex.corner      <= e_k;
      vertex.pos_x       <= POS_W'(e_job.tile_x) + (dx ? POS_W'(e_job.step) : '0);
      vertex.pos_z       <= POS_W'(e_job.tile_z) + (dz ? POS_W'(e_job.step) : '0);
      vertex.pos_y       <= e_job.h[e_k];
      vertex.norm_x      <= nsel[0];
      vertex.norm_y      <= nsel[1];
      vertex.norm_z      <= nsel[2];
      vertex.tex_s       <= TEX_W'(e_job.ats) + TEX_W'(dx);
      vertex.tex_t       <= TEX_W'(e_job.att) + TEX_W'(dz);
      vertex.last_vertex <= (e_k == 2'd3);
    end
  end

endmodule

/* test/heightmap_tile_mesher_tb.sv */
// ---------------------------------------------------------------------------
// heightmap_tile_mesher_tb
// Drives terrain tiles through the mesher and checks each vertex against a
// local predictor of positions, Q1.14 normals and atlas coordinates, across
// several step sizes, with random idling on both sides and stall periods.
// ---------------------------------------------------------------------------
module heightmap_tile_mesher_tb;
  import hmtm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]       corner;
    logic [POS_W-1:0] pos_x;
    logic [H_W-1:0]   pos_y;
    logic [POS_W-1:0] pos_z;
    logic [Q14_W-1:0] norm_x;
    logic [Q14_W-1:0] norm_y;
    logic [Q14_W-1:0] norm_z;
    logic [TEX_W-1:0] tex_s;
    logic [TEX_W-1:0] tex_t;
    logic             last_vertex;
  } vertex_t;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] z;
    logic [H_W-1:0]     ha, hb, hc, hd;
  } tile_t;

  typedef struct {
    tile_t            t;
    bit               known;
    logic [Q14_W-1:0] nx, ny, nz;
    logic [TEX_W-1:0] ts, tt;
  } dir_row_t;

  localparam int LIMIT_CYCLES = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  hmtm_tile_if tile_ch ();
  hmtm_vert_if vert_ch ();
  hmtm_cfg_if  cfg_ch ();

  heightmap_tile_mesher i_dut (
    .clk    (clk),
    .rst    (rst),
    .tile   (tile_ch.sink),
    .vertex (vert_ch.source),
    .cfg    (cfg_ch.sink)
  );

  logic [STEP_W-1:0] step_shadow;
  vertex_t           vertex_queue[$];
  int                mismatches = 0;
  bit                hold_sink = 1'b0;
  longint            cycles = 0;

  // 16384*c/sqrt(l2), nearest, halves away from zero
  function automatic longint q14_scale(longint c, longint l2);
    longint a, lo, hi, mid, d;
    a = (c < 0) ? -c : c;
    lo = 0;
    hi = 16384;
    if (l2 == 0) return 0;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      d = 2 * mid - 1;
      if (d * d * l2 <= ((a * a) << 30)) lo = mid;
      else hi = mid - 1;
    end
    return (c < 0) ? -lo : lo;
  endfunction

  function automatic void unit_vec(input longint v[3], output longint r[3]);
    longint l2;
    l2 = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    for (int i = 0; i < 3; i++) r[i] = q14_scale(v[i], l2);
  endfunction

  task automatic predict_vertices(input tile_t t);
    longint h[4], v1[3], v2[3], sm[3], n1[3], n2[3], na[3], n[3];
    longint s;
    longint mx;
    int ats, att;
    vertex_t e;
    bit dx, dz;
    h[0] = t.ha; h[1] = t.hb; h[2] = t.hc; h[3] = t.hd;
    s = step_shadow;
    n1 = '{0, 0, 0}; n2 = '{0, 0, 0}; na = '{0, 0, 0};
    if (s != 0) begin
      v1 = '{h[1] - h[0], -s, h[2] - h[1]};
      v2 = '{h[2] - h[3], -s, h[3] - h[0]};
      unit_vec(v1, n1);
      unit_vec(v2, n2);
      for (int i = 0; i < 3; i++) sm[i] = n1[i] + n2[i];
      unit_vec(sm, na);
    end
    mx = 0;
    for (int i = 0; i < 4; i++) if (h[i] > mx) mx = h[i];
    if (mx >= TH_SNOW) begin ats = 2; att = 11; end
    else if (mx >= TH_ROCK) begin ats = 3; att = 11; end
    else if (mx >= TH_GRASS) begin ats = 0; att = 14; end
    else if (mx >= TH_SAND) begin ats = 2; att = 15; end
    else begin ats = 0; att = 11; end
    for (int k = 0; k < 4; k++) begin
      dx = (k == 1 || k == 2);
      dz = (k == 2 || k == 3);
      if (k == 1) n = n1;
      else if (k == 3) n = n2;
      else n = na;
      e.corner = 2'(k);
      e.pos_x = POS_W'(t.x + (dx ? step_shadow : 0));
      e.pos_y = H_W'(h[k]);
      e.pos_z = POS_W'(t.z + (dz ? step_shadow : 0));
      e.norm_x = Q14_W'(n[0]);
      e.norm_y = Q14_W'(n[1]);
      e.norm_z = Q14_W'(n[2]);
      e.tex_s = TEX_W'(ats + dx);
      e.tex_t = TEX_W'(att + dz);
      e.last_vertex = (k == 3);
      vertex_queue.push_back(e);
    end
  endtask

  task automatic note_mismatch(input string what, input vertex_t exp_v, input vertex_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected %p, got %p", what, exp_v, got);
  endtask

  // ------------------------------------------------------------ sender
  // valid stays up between back-to-back items; drain and pauses drop it
  task automatic send_tile(input tile_t t, input bit gaps);
    int gap;
    gap = gaps ? int'($urandom_range(0, 14)) : 0;
    if (gap != 0) begin
      tile_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tile_ch.valid    <= 1'b1;
    tile_ch.tile_x   <= t.x;
    tile_ch.tile_z   <= t.z;
    tile_ch.height_a <= t.ha;
    tile_ch.height_b <= t.hb;
    tile_ch.height_c <= t.hc;
    tile_ch.height_d <= t.hd;
    do @(posedge clk); while (!tile_ch.ready);
    predict_vertices(t);
  endtask

  task automatic drain;
    tile_ch.valid <= 1'b0;
    while (vertex_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_step(input logic [STEP_W-1:0] v);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.step_size <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    step_shadow = v;
  endtask

  function automatic tile_t rand_tile(input bit edgy);
    tile_t t;
    int up;
    t.x = (edgy && $urandom_range(0, 3) == 0) ? 12'hFFF : COORD_W'($urandom_range(0, 4095));
    t.z = (edgy && $urandom_range(0, 3) == 0) ? 12'hFFF : COORD_W'($urandom_range(0, 4095));
    t.ha = H_W'($urandom_range(0, 255));
    t.hb = H_W'($urandom_range(0, 255));
    t.hc = H_W'($urandom_range(0, 255));
    t.hd = H_W'($urandom_range(0, 255));
    if (!edgy) begin
      // gentle terrain around a base level reaches every atlas band
      up = int'(t.ha) + int'($urandom_range(0, 20));
      t.hb = (up > 255) ? 8'd255 : H_W'(up);
      t.hc = t.ha ^ H_W'($urandom_range(0, 15));
      t.hd = t.ha;
    end
    return t;
  endfunction

  dir_row_t dir_rows[$];

  task automatic add_row(input int x, z, a, b, c, d, input bit known = 0,
                         input int nx = 0, ny = 0, nz = 0, ts = 0, tt = 0);
    dir_row_t r;
    r.t = '{COORD_W'(x), COORD_W'(z), H_W'(a), H_W'(b), H_W'(c), H_W'(d)};
    r.known = known;
    r.nx = Q14_W'(nx); r.ny = Q14_W'(ny); r.nz = Q14_W'(nz);
    r.ts = TEX_W'(ts); r.tt = TEX_W'(tt);
    dir_rows.push_back(r);
  endtask

  // flat tiles: normal straight down; corner-0 tex by band; then sloped tiles with no table values
  initial begin
    add_row(0, 0, 0, 0, 0, 0, 1, 0, -16384, 0, 0, 11);
    add_row(4095, 4095, 255, 255, 255, 255, 1, 0, -16384, 0, 2, 11);
    add_row(100, 200, 231, 231, 231, 231, 1, 0, -16384, 0, 2, 11);
    add_row(100, 200, 230, 230, 230, 230, 1, 0, -16384, 0, 3, 11);
    add_row(1, 2, 205, 205, 205, 205, 1, 0, -16384, 0, 3, 11);
    add_row(1, 2, 204, 204, 204, 204, 1, 0, -16384, 0, 0, 14);
    add_row(7, 9, 129, 129, 129, 129, 1, 0, -16384, 0, 0, 14);
    add_row(7, 9, 128, 128, 128, 128, 1, 0, -16384, 0, 2, 15);
    add_row(3, 3, 77, 77, 77, 77, 1, 0, -16384, 0, 2, 15);
    add_row(3, 3, 76, 76, 76, 76, 1, 0, -16384, 0, 0, 11);
    add_row(2048, 1024, 0, 255, 0, 255);
    add_row(1024, 2048, 255, 0, 255, 0);
    add_row(4095, 0, 0, 255, 255, 0);
    add_row(0, 4095, 255, 0, 0, 255);
    add_row(2730, 1365, 170, 85, 42, 213);
    add_row(1365, 2730, 85, 170, 213, 42);
  end

  // ------------------------------------------------------------ receiver
  initial begin
    int stall;
    vert_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) vert_ch.ready <= 1'b0;
      else if (vert_ch.ready && vert_ch.valid) begin
        // vertex taken: draw the wait before the next one
        stall = $urandom_range(0, 14);
        if (stall != 0) begin
          vert_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
          vert_ch.ready <= !hold_sink;
        end
      end else vert_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    vertex_t got, exp_v;
    cycles <= cycles + 1;
    if (!rst && vert_ch.valid && vert_ch.ready) begin
      got = '{vert_ch.corner, vert_ch.pos_x, vert_ch.pos_y, vert_ch.pos_z, vert_ch.norm_x,
              vert_ch.norm_y, vert_ch.norm_z, vert_ch.tex_s, vert_ch.tex_t,
              vert_ch.last_vertex};
      if (vertex_queue.size() == 0) note_mismatch("unexpected vertex", '0, got);
      else begin
        exp_v = vertex_queue.pop_front();
        if (got !== exp_v) note_mismatch("vertex", exp_v, got);
      end
    end
    if (cycles > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ------------------------------------------------------------ main
  initial begin
    logic [STEP_W-1:0] steps[6];
    vertex_t got;
    vertex_t exp_v;
    tile_ch.valid <= 1'b0;
    tile_ch.tile_x <= '0; tile_ch.tile_z <= '0;
    tile_ch.height_a <= '0; tile_ch.height_b <= '0;
    tile_ch.height_c <= '0; tile_ch.height_d <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.step_size <= '0;
    step_shadow = STEP_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at reset step
    foreach (dir_rows[i]) begin
      send_tile(dir_rows[i].t, 1'b1);
      if (dir_rows[i].known) begin
        got = vertex_queue[vertex_queue.size() - 4];
        exp_v = got;
        exp_v.norm_x = dir_rows[i].nx;
        exp_v.norm_y = dir_rows[i].ny;
        exp_v.norm_z = dir_rows[i].nz;
        exp_v.tex_s = dir_rows[i].ts;
        exp_v.tex_t = dir_rows[i].tt;
        exp_v.pos_x = POS_W'(dir_rows[i].t.x);
        if (got !== exp_v)
          note_mismatch("predictor table row", exp_v, got);
      end
    end
    drain();

    // zero step: all normals vanish; then step 255
    write_step(8'd0);
    send_tile(dir_rows[10].t, 1'b0);
    send_tile(dir_rows[1].t, 1'b0);
    drain();
    write_step(8'd255);
    send_tile(dir_rows[1].t, 1'b0);
    send_tile(dir_rows[12].t, 1'b0);

    // long receiver hold while tiles keep coming
    hold_sink = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_sink = 1'b0;
      end
      for (int i = 0; i < 6; i++) send_tile(rand_tile(1'b1), 1'b0);
    join
    drain();

    steps = '{8'd1, 8'd255, 8'd0, 8'd37, 8'd128, 8'd10};
    foreach (steps[p]) begin
      write_step(steps[p]);
      for (int i = 0; i < 27; i++) begin
        send_tile(rand_tile($urandom_range(0, 3) == 0), p % 2 == 0 || i > 12);
        if (i == 13) begin
          tile_ch.valid <= 1'b0;
          while (vertex_queue.size() != 0) @(posedge clk);
        end
      end
      drain();
    end

    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
